[sv/csort_pkg.sv]
`default_nettype none

package csort_pkg;

   localparam int MAX_ITEMS  = 64;
   localparam int KEY_BITS   = 8;
   localparam int KEY_W      = 8;
   localparam int HIST_DEPTH = 1 << KEY_BITS;
   localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             batch_end;
   } csort_req_type;

   typedef struct packed {
      logic [KEY_W-1:0] sorted_key;
      logic             run_end;
      logic             overflow;
   } csort_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // input beat taken, read its bin
      logic inc;        // write back bin count + 1
      logic clr_wr;     // clearing pass write
      logic drain_rd;   // read bin at walk pointer
      logic drain_ld;   // load count, zero the bin
      logic bin_step;   // advance walk pointer
      logic emit;       // load one result into output register
      logic batch_clr;  // batch done, clear counters
   } csort_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic last;
      logic bin_last;
      logic rd_zero;
      logic cnt_one;
      logic remain_one;
      logic out_free;
   } csort_sts_type;

endpackage

`default_nettype wire

[sv/csort_datapath.sv]
`default_nettype none

module csort_datapath
   import csort_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  csort_cmd_type cmd,
   output csort_sts_type sts,
   input  csort_req_type req_data,
   output logic          rsp_valid,
   input  wire           rsp_stall,
   output csort_rsp_type rsp_data
);

   logic [CNT_BITS-1:0] hist_mem [HIST_DEPTH];
   logic [CNT_BITS-1:0] rdata_ff;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                last_ff, last_in;
   logic [KEY_BITS-1:0] bin_ff, bin_in;
   logic [CNT_BITS-1:0] held_ff, held_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                dropped_ff, dropped_in;
   logic                rsp_valid_ff, rsp_valid_in;
   csort_rsp_type       rsp_ff, rsp_in;

   logic                mem_we, mem_re;
   logic [KEY_BITS-1:0] mem_waddr, mem_raddr;
   logic [CNT_BITS-1:0] mem_wdata;

   always_comb begin
      mem_we    = cmd.clr_wr | cmd.inc | cmd.drain_ld;
      mem_waddr = cmd.inc ? key_ff : bin_ff;
      mem_wdata = cmd.inc ? rdata_ff + CNT_BITS'(1) : '0;
      mem_re    = cmd.capture | cmd.drain_rd;
      mem_raddr = cmd.capture ? req_data.key[KEY_BITS-1:0] : bin_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= hist_mem[mem_raddr];
      end
   end

   always_comb begin
      key_in       = key_ff;
      last_in      = last_ff;
      bin_in       = bin_ff;
      held_in      = held_ff;
      cnt_in       = cnt_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;

      if (cmd.capture) begin
         key_in  = req_data.key[KEY_BITS-1:0];
         last_in = req_data.batch_end;
         if (sts.full) begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.inc) begin
         held_in = held_ff + CNT_BITS'(1);
      end
      if (cmd.drain_ld) begin
         cnt_in = rdata_ff;
      end
      if (cmd.bin_step) begin
         bin_in = bin_ff + KEY_BITS'(1);
      end
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.sorted_key = KEY_W'(bin_ff);
         rsp_in.run_end    = sts.remain_one;
         rsp_in.overflow   = sts.remain_one & dropped_ff;
         cnt_in            = cnt_ff - CNT_BITS'(1);
         held_in           = held_ff - CNT_BITS'(1);
      end
      if (cmd.batch_clr) begin
         held_in    = '0;
         dropped_in = 1'b0;
         bin_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= 1'b0;
         bin_ff       <= '0;
         held_ff      <= '0;
         cnt_ff       <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         bin_ff       <= bin_in;
         held_ff      <= held_in;
         cnt_ff       <= cnt_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      sts.full       = (held_ff == CNT_BITS'(MAX_ITEMS));
      sts.last       = last_ff;
      sts.bin_last   = (bin_ff == {KEY_BITS{1'b1}});
      sts.rd_zero    = (rdata_ff == '0);
      sts.cnt_one    = (cnt_ff == CNT_BITS'(1));
      sts.remain_one = (held_ff == CNT_BITS'(1));
      sts.out_free   = ~rsp_valid_ff | ~rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_BITS'(MAX_ITEMS))
      else $error("held count beyond batch limit");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (held_ff != '0) && (cnt_ff != '0))
      else $error("emit with empty bin or empty batch");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.remain_one) |=> (held_ff == '0) && !dropped_ff && rsp_data.run_end)
      else $error("final beat did not close the batch");

endmodule

`default_nettype wire

[sv/csort_ctrl.sv]
`default_nettype none

module csort_ctrl
   import csort_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   input  wire           req_batch_end,
   output logic          req_stall,
   input  csort_sts_type sts,
   output csort_cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_INC     = 3'd2;
   localparam logic [2:0] ST_DR_READ = 3'd3;
   localparam logic [2:0] ST_DR_LOAD = 3'd4;
   localparam logic [2:0] ST_DR_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr   = 1'b1;
            cmd.bin_step = 1'b1;
            if (sts.bin_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (!sts.full) begin
                  state_in = ST_INC;
               end else if (req_batch_end) begin
                  state_in = ST_DR_READ;
               end
            end
         end
         ST_INC: begin
            cmd.inc  = 1'b1;
            state_in = sts.last ? ST_DR_READ : ST_IDLE;
         end
         ST_DR_READ: begin
            cmd.drain_rd = 1'b1;
            state_in     = ST_DR_LOAD;
         end
         ST_DR_LOAD: begin
            cmd.drain_ld = 1'b1;
            if (sts.rd_zero) begin
               cmd.bin_step = 1'b1;
               state_in     = ST_DR_READ;
            end else begin
               state_in = ST_DR_EMIT;
            end
         end
         ST_DR_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.remain_one) begin
                  cmd.batch_clr = 1'b1;
                  state_in      = ST_IDLE;
               end else if (sts.cnt_one) begin
                  cmd.bin_step = 1'b1;
                  state_in     = ST_DR_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded over a waiting beat");

   a_inc_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INC) |-> ($past(state_ff) == ST_IDLE) && $past(req_valid))
      else $error("increment without an accepted beat");

   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DR_LOAD) |-> ($past(state_ff) == ST_DR_READ))
      else $error("bin load without a read");

endmodule

`default_nettype wire

[sv/counting_sort_engine.sv]
`default_nettype none
// Counting sort over a stream of 8-bit keys.
// req channel: one key per beat; the beat with batch_end high closes the batch.
// rsp channel: the batch's keys in ascending order, one per beat; run_end marks
// the last beat, overflow on it is set when keys past MAX_ITEMS were dropped.
// Loading: each counted key takes a bin read, then a write-back of count + 1;
// no new key is taken until the write-back. A dropped key takes only the read.
// Drain: starts once the closing key is counted or dropped; each bin from 0 up
// to the last non-empty one is read, then loaded and zeroed, and then gives one
// result per key it holds.
// No new key is taken while a drain runs; the next batch starts after the last
// result is loaded into the output register.
// Reset: a clearing pass over all 256 bins zeroes the histogram; req_stall
// stays high until it ends. Drained bins are zeroed on the way, so no pass is
// needed between batches.
// A stalled rsp beat holds in the output register; the drain pauses until
// the register is free.
module counting_sort_engine
   import csort_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_stall,
   input  csort_req_type req_data,
   output logic          rsp_valid,
   input  wire           rsp_stall,
   output csort_rsp_type rsp_data
);

   csort_cmd_type cmd;
   csort_sts_type sts;

   csort_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_batch_end (req_data.batch_end),
      .req_stall     (req_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   csort_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
